>>> sv/ecpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpe_pkg
// Shared constants and types for the event camera pixel emulator.
// ----------------------------------------------------------------------------
package ecpe_pkg;

    // pixel array size
    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;

    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int unsigned PIX_W = 8;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd10;
    localparam logic [PIX_W-1:0] REFERENCE_RESET = 8'd1;

    // event queue
    localparam int unsigned EVT_FIFO_DEPTH = 4;
    localparam int unsigned EVT_FIFO_AW    = $clog2(EVT_FIFO_DEPTH);
    localparam int unsigned EVT_FIFO_CW    = EVT_FIFO_AW + 1;

    localparam logic POL_BRIGHTER = 1'b0;
    localparam logic POL_DARKER   = 1'b1;

    typedef logic [STORE_AW-1:0] store_addr_t;

    typedef struct packed {
        logic             polarity;
        logic [PIX_W-1:0] ev_y;
        logic [PIX_W-1:0] ev_x;
    } event_t;

endpackage

>>> sv/ecpe_ref_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpe_ref_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ecpe_ref_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write on an address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ecpe_evt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpe_evt_fifo
// Small event queue between the compare stage and the output channel.
// ----------------------------------------------------------------------------
module ecpe_evt_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  ecpe_pkg::event_t                    push_data,
    input  logic                                pop,
    output logic                                not_empty,
    output ecpe_pkg::event_t                    head,
    output logic [ecpe_pkg::EVT_FIFO_CW-1:0]    count
);

    ecpe_pkg::event_t                    buf_mem [ecpe_pkg::EVT_FIFO_DEPTH];
    logic [ecpe_pkg::EVT_FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ecpe_pkg::EVT_FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ecpe_pkg::EVT_FIFO_CW-1:0]    cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = buf_mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

>>> sv/event_camera_pixel_emulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_camera_pixel_emulator
// Event camera pixel array model: per-pixel reference compare, event output.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one pixel word per accepted beat (column, row, intensity).
//   m_ channel gives one event word for each pixel whose intensity moved more
//   than the threshold away from its stored reference; quiet pixels give none.
//   cfg_wr_en / cfg_wr_data load the threshold (reset value 10); write it
//   only while the block is idle.
// Throughput: one pixel per clock while s_tready is high, set by the single
//   read-modify-write of the reference RAM (read at accept, compare and write
//   back in the next cycle, with a bypass for back-to-back hits on the same pixel).
// Output: an accepted pixel is registered in the compare stage, and its event
//   word is then pushed into the event queue, whose non-empty flag is m_tvalid.
// Reset: aresetn (synchronous, active low) clears control state and starts a
//   clearing pass that writes 1 to every reference entry, one entry a cycle
//   (65536 entries with the 256 x 256 array). s_tready stays low meanwhile.
// Stall: events queue in a four-word buffer; s_tready drops during the clearing
//   pass and when that buffer plus the compare stage could not take another event.
// ----------------------------------------------------------------------------
module event_camera_pixel_emulator (
    input  logic        aclk,
    input  logic        aresetn,
    // threshold register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] pix_x, [15:8] pix_y, [23:16] intensity
    // event output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] ev_x, [15:8] ev_y, [16] polarity, rest 0
);

    localparam ecpe_pkg::store_addr_t LAST_ADDR =
        ecpe_pkg::STORE_AW'(ecpe_pkg::STORE_DEPTH - 1);

    // input word fields
    logic [ecpe_pkg::PIX_W-1:0] pix_x, pix_y, intensity;
    assign pix_x     = s_tdata[7:0];
    assign pix_y     = s_tdata[15:8];
    assign intensity = s_tdata[23:16];

    // threshold
    logic [ecpe_pkg::PIX_W-1:0] event_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_threshold_reg <= ecpe_pkg::THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            event_threshold_reg <= cfg_wr_data;
        end
    end

    // clearing pass after reset
    logic                  clearing_reg;
    ecpe_pkg::store_addr_t clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // accept and address
    logic                  s_accept;
    logic                  in_range;
    ecpe_pkg::store_addr_t in_addr;

    assign s_accept = s_tvalid && s_tready;
    assign in_range = (32'(pix_x) < ecpe_pkg::MAX_WIDTH) &&
                      (32'(pix_y) < ecpe_pkg::MAX_HEIGHT);
    assign in_addr  = ecpe_pkg::STORE_AW'(32'(pix_y) * ecpe_pkg::MAX_WIDTH + 32'(pix_x));

    // compare stage: RAM data arrives here
    logic                       s1_valid_reg;
    ecpe_pkg::store_addr_t      s1_addr_reg;
    logic [ecpe_pkg::PIX_W-1:0] s1_x_reg, s1_y_reg, s1_int_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg <= in_addr;
            s1_x_reg    <= pix_x;
            s1_y_reg    <= pix_y;
            s1_int_reg  <= intensity;
        end
    end

    // bypass of the write made on the edge this pixel was read
    logic                       fwd_valid_reg;
    ecpe_pkg::store_addr_t      fwd_addr_reg;
    logic [ecpe_pkg::PIX_W-1:0] fwd_data_reg;

    logic [ecpe_pkg::PIX_W-1:0] rd_data;
    logic [ecpe_pkg::PIX_W-1:0] ref_val;
    logic                       brighter, darker, fire;

    assign ref_val  = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                       : rd_data;
    assign brighter = (s1_int_reg > ref_val) &&
                      ((s1_int_reg - ref_val) > event_threshold_reg);
    assign darker   = (ref_val > s1_int_reg) &&
                      ((ref_val - s1_int_reg) > event_threshold_reg);
    assign fire     = s1_valid_reg && (brighter || darker);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= s1_int_reg;
        end
    end

    // reference RAM: clearing pass or write-back share the write port
    logic                       ram_wr_en;
    ecpe_pkg::store_addr_t      ram_wr_addr;
    logic [ecpe_pkg::PIX_W-1:0] ram_wr_data;

    assign ram_wr_en   = clearing_reg || fire;
    assign ram_wr_addr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wr_data = clearing_reg ? ecpe_pkg::REFERENCE_RESET : s1_int_reg;

    ecpe_ref_ram #(
        .DATA_W (ecpe_pkg::PIX_W),
        .ADDR_W (ecpe_pkg::STORE_AW)
    ) u_ref_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept && in_range),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    // event queue
    ecpe_pkg::event_t                 ev_push, ev_head;
    logic                             fifo_not_empty;
    logic [ecpe_pkg::EVT_FIFO_CW-1:0] fifo_cnt;

    assign ev_push.ev_x     = s1_x_reg;
    assign ev_push.ev_y     = s1_y_reg;
    assign ev_push.polarity = brighter ? ecpe_pkg::POL_BRIGHTER : ecpe_pkg::POL_DARKER;

    ecpe_evt_fifo u_evt_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .push_data (ev_push),
        .pop       (m_tvalid && m_tready),
        .not_empty (fifo_not_empty),
        .head      (ev_head),
        .count     (fifo_cnt)
    );

    // room for the compare stage's event and one more
    assign s_tready = !clearing_reg &&
                      ((32'(fifo_cnt) + 32'(s1_valid_reg)) < ecpe_pkg::EVT_FIFO_DEPTH);

    assign m_tvalid = fifo_not_empty;
    assign m_tdata  = {7'b0, ev_head.polarity, ev_head.ev_y, ev_head.ev_x};

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> (32'(fifo_cnt) < ecpe_pkg::EVT_FIFO_DEPTH))
        else $error("event queue overflow");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready && !s1_valid_reg)
        else $error("pixel taken during clearing pass");

    a_bypass_track: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> fwd_valid_reg && (fwd_addr_reg == $past(s1_addr_reg)) &&
                 (fwd_data_reg == $past(s1_int_reg)))
        else $error("bypass register lost a write-back");

    a_one_polarity: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> !(brighter && darker))
        else $error("both polarities at once");
`endif

endmodule
